/* rtl/core/hrp_pkg.sv */
// Shared types, constants and character tables of the HTTP response parser.
package hrp_pkg;

  localparam int unsigned LENGTH_BITS = 32;
  localparam int unsigned LEN_W       = LENGTH_BITS + 4;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [4:0] PREFIX_LEN  = 5'd9;
  localparam logic [4:0] LEN_HDR_LEN = 5'd14;
  localparam logic [4:0] ENC_HDR_LEN = 5'd17;
  localparam logic [4:0] IDX_MAX     = 5'd31;
  localparam logic [3:0] STATUS_MIN  = 4'd13;
  localparam logic [3:0] CODE_START  = 4'd9;
  localparam logic [3:0] LINE_MAX    = 4'd15;
  localparam logic [1:0] DIGITS_MAX  = 2'd3;

  typedef enum logic [3:0] {
    PH_PREFIX,
    PH_STATUS,
    PH_NAME,
    PH_SKIP,
    PH_VALUE,
    PH_BODY,
    PH_DONE
  } hrp_phase_e;

  typedef enum logic [2:0] {
    K_STATUS,
    K_NAME,
    K_VALUE,
    K_LINE_END,
    K_HDR_DONE,
    K_BODY,
    K_ERROR,
    K_IGNORED
  } hrp_kind_e;

  typedef struct packed {
    hrp_phase_e             phase;
    logic [4:0]             match_index;
    logic [3:0]             line_length;
    logic [9:0]             status_acc;
    logic [1:0]             status_digits;
    logic [1:0]             name_flags;
    logic                   value_digits_seen;
    logic                   value_ended;
    logic                   prev_cr;
    logic [LENGTH_BITS-1:0] length;
    logic [LENGTH_BITS-1:0] body_count;
    logic                   error;
  } hrp_state_t;

  typedef struct packed {
    hrp_kind_e   kind;
    logic [7:0]  byte_value;
    logic [9:0]  resp_code;
    logic [31:0] body_length;
    logic        last;
  } hrp_result_t;

  // "HTTP/1.1 "
  function automatic logic [7:0] prefix_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = 8'h48;
      4'd1:    c = 8'h54;
      4'd2:    c = 8'h54;
      4'd3:    c = 8'h50;
      4'd4:    c = 8'h2f;
      4'd5:    c = 8'h31;
      4'd6:    c = 8'h2e;
      4'd7:    c = 8'h31;
      4'd8:    c = 8'h20;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "Content-Length"
  function automatic logic [7:0] len_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = 8'h43;
      4'd1:    c = 8'h6f;
      4'd2:    c = 8'h6e;
      4'd3:    c = 8'h74;
      4'd4:    c = 8'h65;
      4'd5:    c = 8'h6e;
      4'd6:    c = 8'h74;
      4'd7:    c = 8'h2d;
      4'd8:    c = 8'h4c;
      4'd9:    c = 8'h65;
      4'd10:   c = 8'h6e;
      4'd11:   c = 8'h67;
      4'd12:   c = 8'h74;
      4'd13:   c = 8'h68;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "Transfer-Encoding"
  function automatic logic [7:0] enc_char(input logic [4:0] idx);
    logic [7:0] c;
    unique case (idx)
      5'd0:    c = 8'h54;
      5'd1:    c = 8'h72;
      5'd2:    c = 8'h61;
      5'd3:    c = 8'h6e;
      5'd4:    c = 8'h73;
      5'd5:    c = 8'h66;
      5'd6:    c = 8'h65;
      5'd7:    c = 8'h72;
      5'd8:    c = 8'h2d;
      5'd9:    c = 8'h45;
      5'd10:   c = 8'h6e;
      5'd11:   c = 8'h63;
      5'd12:   c = 8'h6f;
      5'd13:   c = 8'h64;
      5'd14:   c = 8'h69;
      5'd15:   c = 8'h6e;
      5'd16:   c = 8'h67;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

/* rtl/core/hrp_in_if.sv */
// Input channel: one received byte per item.
interface hrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

/* rtl/core/hrp_out_if.sv */
// Output channel: one parse event per item.
interface hrp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  byte_value;
  logic [9:0]  resp_code;
  logic [31:0] body_length;
  logic        last;

  modport source (output valid, output kind, output byte_value, output resp_code,
                  output body_length, output last, input ready);
  modport sink (input valid, input kind, input byte_value, input resp_code,
                input body_length, input last, output ready);
endinterface

/* rtl/core/hrp_in_stage.sv */
// Input register of the parser: holds one byte until the parse step consumes it.
module hrp_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] in_byte_i,
  output logic       in_ready_o,
  input  logic       take_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q;
  logic [7:0] byte_q;

  assign in_ready_o = !valid_q || take_i;
  assign valid_o    = valid_q;
  assign byte_o     = byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= in_byte_i;
    end
  end

endmodule

/* rtl/core/hrp_parse.sv */
// Parser state registers and the per-byte next-state and event logic.
module hrp_parse (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           byte_i,
  output hrp_pkg::hrp_result_t result_o
);

  localparam int unsigned LB = hrp_pkg::LENGTH_BITS;
  localparam int unsigned LW = hrp_pkg::LEN_W;

  hrp_pkg::hrp_state_t state_q, state_d;

  logic          is_cr, is_lf, is_colon, is_blank, is_digit;
  logic [3:0]    dig;
  logic          prefix_ok;
  logic [3:0]    ll_a, ll_b;
  logic          code_take;
  logic [9:0]    acc_next;
  logic          status_bad;
  logic          len_hit, enc_hit, len_miss, enc_miss;
  logic          len_active;
  logic [LW-1:0] len_ext, len_wide;
  logic          len_ovf;
  logic          body_more, body_last;
  logic [LB-1:0] body_inc;
  logic [LB+31:0] len_pad;
  logic [31:0]   len32;
  logic          skipping;
  logic          fail;

  assign is_cr    = byte_i == hrp_pkg::CH_CR;
  assign is_lf    = byte_i == hrp_pkg::CH_LF;
  assign is_colon = byte_i == hrp_pkg::CH_COLON;
  assign is_blank = (byte_i == hrp_pkg::CH_SP) || (byte_i == hrp_pkg::CH_TAB);
  assign is_digit = (byte_i >= hrp_pkg::CH_ZERO) && (byte_i <= hrp_pkg::CH_NINE);
  assign dig      = byte_i[3:0];

  assign prefix_ok = (state_q.match_index < hrp_pkg::PREFIX_LEN) &&
                     (byte_i == hrp_pkg::prefix_char(state_q.match_index[3:0]));

  // pending CR in the status line counts as one ordinary char first
  assign ll_a = (state_q.prev_cr && state_q.line_length != hrp_pkg::LINE_MAX) ?
                state_q.line_length + 4'd1 : state_q.line_length;
  assign ll_b = (ll_a != hrp_pkg::LINE_MAX) ? ll_a + 4'd1 : ll_a;
  assign code_take = (ll_a >= hrp_pkg::CODE_START) && is_digit &&
                     (state_q.status_digits < hrp_pkg::DIGITS_MAX) &&
                     ({2'b00, state_q.status_digits} == ll_a - hrp_pkg::CODE_START);
  assign acc_next = (state_q.status_acc << 3) + (state_q.status_acc << 1) + {6'd0, dig};
  assign status_bad = (state_q.line_length < hrp_pkg::STATUS_MIN) ||
                      (state_q.status_digits == 2'd0);

  assign len_hit  = state_q.name_flags[0] && (state_q.match_index == hrp_pkg::LEN_HDR_LEN);
  assign enc_hit  = state_q.name_flags[1] && (state_q.match_index == hrp_pkg::ENC_HDR_LEN);
  assign len_miss = (state_q.match_index >= hrp_pkg::LEN_HDR_LEN) ||
                    (byte_i != hrp_pkg::len_char(state_q.match_index[3:0]));
  assign enc_miss = (state_q.match_index >= hrp_pkg::ENC_HDR_LEN) ||
                    (byte_i != hrp_pkg::enc_char(state_q.match_index));

  assign len_active = state_q.name_flags[0] && !state_q.value_ended;
  assign len_ext    = {4'd0, state_q.length};
  assign len_wide   = (len_ext << 3) + (len_ext << 1) + LW'(dig);
  assign len_ovf    = |len_wide[LW-1:LB];

  assign body_more = state_q.body_count < state_q.length;
  assign body_inc  = state_q.body_count + LB'(1);
  assign body_last = body_inc == state_q.length;

  assign len_pad = {32'd0, state_q.length};
  assign len32   = len_pad[31:0];

  assign skipping = (state_q.phase == hrp_pkg::PH_SKIP) && is_blank;

  always_comb begin
    fail = 1'b0;
    if (state_q.error) begin
      fail = 1'b1;
    end else begin
      unique case (state_q.phase)
        hrp_pkg::PH_PREFIX: fail = !prefix_ok;
        hrp_pkg::PH_STATUS: fail = state_q.prev_cr && is_lf && status_bad;
        hrp_pkg::PH_NAME: begin
          if (state_q.prev_cr) begin
            fail = !is_lf;
          end else if (is_cr) begin
            fail = state_q.match_index != 5'd0;
          end else begin
            fail = is_colon && enc_hit;
          end
        end
        hrp_pkg::PH_SKIP, hrp_pkg::PH_VALUE: begin
          if (state_q.prev_cr) begin
            fail = !is_lf || (state_q.name_flags[0] && !state_q.value_digits_seen);
          end else begin
            fail = !is_cr && !skipping && len_active && is_digit && len_ovf;
          end
        end
        default: fail = 1'b0;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    if (fail) begin
      state_d.error = 1'b1;
    end else begin
      unique case (state_q.phase)
        hrp_pkg::PH_PREFIX: begin
          state_d.match_index = state_q.match_index + 5'd1;
          if (state_q.match_index == hrp_pkg::PREFIX_LEN - 5'd1) begin
            state_d.line_length = hrp_pkg::CODE_START;
            state_d.phase       = hrp_pkg::PH_STATUS;
          end
        end
        hrp_pkg::PH_STATUS: begin
          if (state_q.prev_cr && is_lf) begin
            state_d.match_index = 5'd0;
            state_d.name_flags  = 2'b11;
            state_d.prev_cr     = 1'b0;
            state_d.phase       = hrp_pkg::PH_NAME;
          end else if (is_cr) begin
            state_d.prev_cr     = 1'b1;
            state_d.line_length = ll_a;
          end else begin
            state_d.prev_cr     = 1'b0;
            state_d.line_length = ll_b;
            if (code_take) begin
              state_d.status_acc    = acc_next;
              state_d.status_digits = state_q.status_digits + 2'd1;
            end
          end
        end
        hrp_pkg::PH_NAME: begin
          if (state_q.prev_cr) begin
            state_d.prev_cr = 1'b0;
            state_d.phase   = (state_q.length == '0) ? hrp_pkg::PH_DONE : hrp_pkg::PH_BODY;
          end else if (is_cr) begin
            state_d.prev_cr = 1'b1;
          end else if (is_colon) begin
            state_d.name_flags = {1'b0, len_hit};
            if (len_hit) begin
              state_d.length            = '0;
              state_d.value_digits_seen = 1'b0;
              state_d.value_ended       = 1'b0;
            end
            state_d.phase = hrp_pkg::PH_SKIP;
          end else begin
            state_d.name_flags[0] = state_q.name_flags[0] && !len_miss;
            state_d.name_flags[1] = state_q.name_flags[1] && !enc_miss;
            if (state_q.match_index != hrp_pkg::IDX_MAX) begin
              state_d.match_index = state_q.match_index + 5'd1;
            end
          end
        end
        hrp_pkg::PH_SKIP, hrp_pkg::PH_VALUE: begin
          if (state_q.prev_cr) begin
            state_d.match_index = 5'd0;
            state_d.name_flags  = 2'b11;
            state_d.prev_cr     = 1'b0;
            state_d.phase       = hrp_pkg::PH_NAME;
          end else if (is_cr) begin
            state_d.prev_cr = 1'b1;
          end else if (!skipping) begin
            state_d.phase = hrp_pkg::PH_VALUE;
            if (len_active) begin
              if (is_digit) begin
                state_d.length            = len_wide[LB-1:0];
                state_d.value_digits_seen = 1'b1;
              end else begin
                state_d.value_ended = 1'b1;
              end
            end
          end
        end
        hrp_pkg::PH_BODY: begin
          if (body_more) begin
            state_d.body_count = body_inc;
            if (body_last) begin
              state_d.phase = hrp_pkg::PH_DONE;
            end
          end else begin
            state_d.phase = hrp_pkg::PH_DONE;
          end
        end
        default: state_d = state_q;
      endcase
    end
  end

  // event for this byte
  always_comb begin
    result_o = '{kind: hrp_pkg::K_IGNORED, byte_value: 8'd0, resp_code: 10'd0,
                 body_length: 32'd0, last: 1'b0};
    if (fail) begin
      result_o.kind = hrp_pkg::K_ERROR;
    end else begin
      unique case (state_q.phase)
        hrp_pkg::PH_PREFIX, hrp_pkg::PH_STATUS: result_o.kind = hrp_pkg::K_STATUS;
        hrp_pkg::PH_NAME: begin
          if (state_q.prev_cr) begin
            result_o.kind        = hrp_pkg::K_HDR_DONE;
            result_o.resp_code   = state_q.status_acc;
            result_o.body_length = len32;
            result_o.last        = state_q.length == '0;
          end else if (!is_cr && !is_colon) begin
            result_o.kind       = hrp_pkg::K_NAME;
            result_o.byte_value = byte_i;
          end
        end
        hrp_pkg::PH_SKIP, hrp_pkg::PH_VALUE: begin
          if (state_q.prev_cr) begin
            result_o.kind = hrp_pkg::K_LINE_END;
          end else if (!is_cr && !skipping) begin
            result_o.kind       = hrp_pkg::K_VALUE;
            result_o.byte_value = byte_i;
          end
        end
        hrp_pkg::PH_BODY: begin
          if (body_more) begin
            result_o.kind       = hrp_pkg::K_BODY;
            result_o.byte_value = byte_i;
            result_o.last       = body_last;
          end
        end
        default: result_o.kind = hrp_pkg::K_IGNORED;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: hrp_pkg::PH_PREFIX, match_index: 5'd0, line_length: 4'd0,
                   status_acc: 10'd0, status_digits: 2'd0, name_flags: 2'b11,
                   value_digits_seen: 1'b0, value_ended: 1'b0, prev_cr: 1'b0,
                   length: '0, body_count: '0, error: 1'b0};
    end else if (step_i) begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  a_error_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.error |=> state_q.error)
    else $error("error latch cleared");
  a_fail_latches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && fail) |=> (state_q.error && $past(result_o.kind) == hrp_pkg::K_ERROR))
    else $error("failed byte did not latch error");
  a_body_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase == hrp_pkg::PH_BODY) |-> (state_q.body_count < state_q.length))
    else $error("body count reached length while still in body");
  a_prefix_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase == hrp_pkg::PH_PREFIX) |-> (state_q.match_index < hrp_pkg::PREFIX_LEN))
    else $error("prefix index out of range");
`endif

endmodule

/* rtl/core/hrp_out_stage.sv */
// Result register of the parser, driving the output channel.
module hrp_out_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  hrp_pkg::hrp_result_t result_i,
  output logic                 free_o,
  hrp_out_if.source            out_o
);

  logic                 valid_q;
  hrp_pkg::hrp_result_t result_q;

  assign free_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      result_q <= result_i;
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.kind        = result_q.kind;
  assign out_o.byte_value  = result_q.byte_value;
  assign out_o.resp_code   = result_q.resp_code;
  assign out_o.body_length = result_q.body_length;
  assign out_o.last        = result_q.last;

endmodule

/* rtl/core/http_response_header_parser_unit.sv */
// HTTP/1.1 response parser: byte stream in, one tagged event per byte out.
//
// in_i carries one received byte per item (data_byte); out_o returns exactly one
// event per byte: kind, byte_value, resp_code, body_length and last.
// Both channels use valid/ready; an item moves when both are high at clk_i.
// The byte is registered on entry, parsed combinationally against the header
// state and the event is registered on exit: out_o.valid rises when the parsed
// event moves from the input register into the output register, and one byte
// per cycle is taken continuously while out_o.ready stays high.
// The rate is set by the state update of the parse step; the
// widest path there is the content-length multiply-by-ten and overflow check.
// When out_o.ready is low, the held event stays put, one more byte waits in
// the input register, and in_i.ready drops once both registers are full.
// rst_ni (asynchronous, active low) empties both registers and returns the
// parser to matching the status line prefix with a zero content length.
// Once a protocol error is seen, every further byte answers an error event
// until reset.
module http_response_header_parser_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  hrp_in_if.sink    in_i,
  hrp_out_if.source out_o
);

  logic                 held_valid;
  logic [7:0]           held_byte;
  logic                 out_free;
  logic                 step;
  hrp_pkg::hrp_result_t result;

  assign step = held_valid && out_free;

  hrp_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_byte_i  (in_i.data_byte),
    .in_ready_o (in_i.ready),
    .take_i     (step),
    .valid_o    (held_valid),
    .byte_o     (held_byte)
  );

  hrp_parse u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (held_byte),
    .result_o (result)
  );

  hrp_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (held_valid),
    .result_i (result),
    .free_o   (out_free),
    .out_o    (out_o)
  );

endmodule

/* test/tb_http_response_header_parser_unit.sv */
// Testbench for the HTTP response parser: one randomized response stream, checked per byte.
`timescale 1ns / 100ps

module tb_http_response_header_parser_unit;

  localparam logic [7:0] CR    = 8'h0d;
  localparam logic [7:0] LF    = 8'h0a;
  localparam logic [7:0] COLON = 8'h3a;
  localparam logic [7:0] SP    = 8'h20;
  localparam logic [7:0] TAB   = 8'h09;
  localparam logic [7:0] ZERO  = 8'h30;
  localparam logic [7:0] NINE  = 8'h39;

  localparam int STREAM_BYTES = 1400;
  localparam int STALL_AT     = 100;
  localparam int STALL_CYCLES = 80;
  localparam int WATCHDOG     = 5000;
  localparam int SETTLE       = 10;

  localparam longint unsigned LEN_MAX = (hrp_pkg::LENGTH_BITS >= 64) ?
                                        64'hFFFF_FFFF_FFFF_FFFF :
                                        (64'd1 << hrp_pkg::LENGTH_BITS) - 64'd1;

  typedef enum int {
    SC_BAD_PREFIX,
    SC_SHORT_STATUS,
    SC_NO_DIGIT,
    SC_CHUNKED,
    SC_CR_IN_NAME,
    SC_BAD_BLANK,
    SC_LONE_CR_VALUE,
    SC_NO_LENGTH_DIGIT,
    SC_LENGTH_OVERFLOW,
    SC_DEFAULT_LENGTH,
    SC_COMPLETE
  } scenario_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  hrp_in_if  in_if ();
  hrp_out_if out_if ();

  http_response_header_parser_unit DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  string version_prefix = "HTTP/1.1 ";
  string length_name    = "Content-Length";
  string encoding_name  = "Transfer-Encoding";

  // parser state
  hrp_pkg::hrp_phase_e p_phase;
  logic [4:0]          p_idx;
  logic [3:0]          p_line;
  logic [9:0]          p_code;
  logic [1:0]          p_digits;
  logic [1:0]          p_flags;
  bit                  p_seen;
  bit                  p_ended;
  bit                  p_cr;
  bit                  p_err;
  longint unsigned     p_len;
  longint unsigned     p_body;

  logic [7:0]           stream_q[$];
  hrp_pkg::hrp_result_t event_q[$];
  hrp_pkg::hrp_result_t want;
  scenario_e            scenario;

  int  n_total = STREAM_BYTES;
  int  bytes_in;
  int  events_out;
  int  errors;
  int  idle_cycles;
  int  kind_count[8];
  int  send_idle_pct = 25;
  int  recv_idle_pct = 49;
  int  stall_left;
  bit  stall_done;
  bit  in_sent;
  bit  out_taken;

  function automatic hrp_pkg::hrp_result_t make_event(input hrp_pkg::hrp_kind_e k,
                                                      input logic [7:0] b,
                                                      input logic [9:0] code,
                                                      input logic [31:0] len,
                                                      input logic last);
    hrp_pkg::hrp_result_t r;
    r.kind        = k;
    r.byte_value  = b;
    r.resp_code   = code;
    r.body_length = len;
    r.last        = last;
    return r;
  endfunction

  function automatic hrp_pkg::hrp_result_t raise_error();
    p_err = 1'b1;
    return make_event(hrp_pkg::K_ERROR, 8'd0, 10'd0, 32'd0, 1'b0);
  endfunction

  function automatic hrp_pkg::hrp_result_t plain_event(input hrp_pkg::hrp_kind_e k);
    return make_event(k, 8'd0, 10'd0, 32'd0, 1'b0);
  endfunction

  function automatic void reset_parser();
    p_phase  = hrp_pkg::PH_PREFIX;
    p_idx    = 5'd0;
    p_line   = 4'd0;
    p_code   = 10'd0;
    p_digits = 2'd0;
    p_flags  = 2'b11;
    p_seen   = 1'b0;
    p_ended  = 1'b0;
    p_cr     = 1'b0;
    p_err    = 1'b0;
    p_len    = 0;
    p_body   = 0;
  endfunction

  function automatic void start_line();
    p_idx   = 5'd0;
    p_flags = 2'b11;
    p_cr    = 1'b0;
    p_phase = hrp_pkg::PH_NAME;
  endfunction

  // code digits count only while they directly follow the prefix
  function automatic void count_status_char(input logic [7:0] c);
    if (p_line >= 4'd9 && c >= ZERO && c <= NINE && p_digits < 2'd3 &&
        int'(p_digits) == int'(p_line) - 9) begin
      p_code   = p_code * 10'd10 + 10'(c - ZERO);
      p_digits = p_digits + 2'd1;
    end
    if (p_line < 4'd15) p_line = p_line + 4'd1;
  endfunction

  function automatic hrp_pkg::hrp_result_t parse_byte(input logic [7:0] b);
    bit              is_len;
    bit              is_enc;
    longint unsigned d;
    if (p_err) return raise_error();
    case (p_phase)
      hrp_pkg::PH_PREFIX: begin
        if (p_idx >= 5'd9 || b != version_prefix[p_idx]) return raise_error();
        p_idx = p_idx + 5'd1;
        if (p_idx == 5'd9) begin
          p_line  = 4'd9;
          p_phase = hrp_pkg::PH_STATUS;
        end
        return plain_event(hrp_pkg::K_STATUS);
      end
      hrp_pkg::PH_STATUS: begin
        if (p_cr) begin
          if (b == LF) begin
            if (p_line < 4'd13 || p_digits == 2'd0) return raise_error();
            start_line();
            return plain_event(hrp_pkg::K_STATUS);
          end
          p_cr = 1'b0;
          count_status_char(CR);
        end
        if (b == CR) p_cr = 1'b1;
        else count_status_char(b);
        return plain_event(hrp_pkg::K_STATUS);
      end
      hrp_pkg::PH_NAME: begin
        if (p_cr) begin
          if (b != LF) return raise_error();
          p_cr    = 1'b0;
          p_phase = (p_len == 0) ? hrp_pkg::PH_DONE : hrp_pkg::PH_BODY;
          return make_event(hrp_pkg::K_HDR_DONE, 8'd0, p_code, p_len[31:0], p_len == 0);
        end
        if (b == CR) begin
          if (p_idx != 5'd0) return raise_error();
          p_cr = 1'b1;
          return plain_event(hrp_pkg::K_IGNORED);
        end
        if (b == COLON) begin
          is_len = p_flags[0] && p_idx == 5'd14;
          is_enc = p_flags[1] && p_idx == 5'd17;
          if (is_enc) return raise_error();
          p_flags = is_len ? 2'b01 : 2'b00;
          if (is_len) begin
            p_len   = 0;
            p_seen  = 1'b0;
            p_ended = 1'b0;
          end
          p_phase = hrp_pkg::PH_SKIP;
          return plain_event(hrp_pkg::K_IGNORED);
        end
        if (p_flags[0] && (p_idx >= 5'd14 || b != length_name[p_idx])) p_flags[0] = 1'b0;
        if (p_flags[1] && (p_idx >= 5'd17 || b != encoding_name[p_idx])) p_flags[1] = 1'b0;
        if (p_idx < 5'd31) p_idx = p_idx + 5'd1;
        return make_event(hrp_pkg::K_NAME, b, 10'd0, 32'd0, 1'b0);
      end
      hrp_pkg::PH_SKIP, hrp_pkg::PH_VALUE: begin
        if (p_cr) begin
          if (b != LF) return raise_error();
          if (p_flags[0] && !p_seen) return raise_error();
          start_line();
          return plain_event(hrp_pkg::K_LINE_END);
        end
        if (b == CR) begin
          p_cr = 1'b1;
          return plain_event(hrp_pkg::K_IGNORED);
        end
        if (p_phase == hrp_pkg::PH_SKIP && (b == SP || b == TAB))
          return plain_event(hrp_pkg::K_IGNORED);
        p_phase = hrp_pkg::PH_VALUE;
        if (p_flags[0] && !p_ended) begin
          if (b >= ZERO && b <= NINE) begin
            d = longint'(b - ZERO);
            if (p_len > (LEN_MAX - d) / 10) return raise_error();
            p_len  = p_len * 10 + d;
            p_seen = 1'b1;
          end else begin
            p_ended = 1'b1;
          end
        end
        return make_event(hrp_pkg::K_VALUE, b, 10'd0, 32'd0, 1'b0);
      end
      hrp_pkg::PH_BODY: begin
        if (p_body < p_len) begin
          p_body = p_body + 1;
          if (p_body == p_len) p_phase = hrp_pkg::PH_DONE;
          return make_event(hrp_pkg::K_BODY, b, 10'd0, 32'd0, p_body == p_len);
        end
        p_phase = hrp_pkg::PH_DONE;
      end
      default: ;
    endcase
    return plain_event(hrp_pkg::K_IGNORED);
  endfunction

  function automatic logic [7:0] rand_char(input bit no_colon);
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (c == CR || (no_colon && c == COLON));
    return c;
  endfunction

  task automatic add_byte(input logic [7:0] b);
    stream_q.insert(stream_q.size(), b);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic push_header(input string name, input string value);
    push_text(name);
    add_byte(COLON);
    push_text(value);
    add_byte(CR);
    add_byte(LF);
  endtask

  task automatic build_response();
    int         n;
    int         body_len;
    logic [7:0] c;
    n = $urandom_range(0, 19);
    scenario = (n > int'(SC_COMPLETE)) ? SC_COMPLETE : scenario_e'(n);
    if (scenario == SC_BAD_PREFIX) begin
      n = $urandom_range(0, 8);
      for (int i = 0; i < n; i++) add_byte(version_prefix[i]);
      do c = 8'($urandom_range(255)); while (c == version_prefix[n]);
      add_byte(c);
    end else if (scenario == SC_SHORT_STATUS) begin
      push_text("HTTP/1.1 200\015\n");
    end else if (scenario == SC_NO_DIGIT) begin
      push_text("HTTP/1.1 OK, no code\015\n");
    end else begin
      push_text(version_prefix);
      repeat ($urandom_range(1, 3)) add_byte(ZERO + 8'($urandom_range(9)));
      if ($urandom_range(3) == 0) begin
        add_byte(CR);
        add_byte("X");
      end
      repeat ($urandom_range(4, 16)) add_byte(rand_char(1'b0));
      push_text("\015\n");

      if (scenario != SC_DEFAULT_LENGTH) begin
        push_header("Content-Length", " 4294967295");
        push_header("Content-Length", "\t 00012abc");
        push_header("Content-Length", "0");
      end
      push_header("", "empty name");
      push_header("content-length", " x");
      push_header("Content-Lengthy", " q");
      push_header("Content-Len", " 7");
      push_header("Transfer-Encodin", " chunked");
      push_header("Transfer-Encodingx", " chunked");
      push_header("X-Header-Name-Well-Past-Thirty-One-Bytes", " v");
      push_header("Host", "");
      push_header("A", " \t \t");
      push_header("B", " a: b c");
      add_byte("N");
      add_byte(LF);
      add_byte(8'hff);
      add_byte(COLON);
      add_byte(8'h80);
      add_byte(8'h00);
      add_byte(8'h7f);
      push_text("\015\n");

      repeat ($urandom_range(20, 35)) begin
        if (scenario != SC_DEFAULT_LENGTH && $urandom_range(7) == 0) begin
          push_header("Content-Length", $sformatf("%s%0d", $urandom_range(1) ? " " : "",
                                                  $urandom_range(0, 999999999)));
        end else begin
          repeat ($urandom_range(1, 24)) add_byte(rand_char(1'b1));
          add_byte(COLON);
          repeat ($urandom_range(0, 2)) add_byte($urandom_range(1) ? SP : TAB);
          repeat ($urandom_range(0, 16)) add_byte(rand_char(1'b0));
          push_text("\015\n");
        end
      end

      case (scenario)
        SC_CHUNKED:         push_header("Transfer-Encoding", " chunked");
        SC_CR_IN_NAME:      push_text("Bad-Name\015\n");
        SC_BAD_BLANK:       push_text("\015x");
        SC_LONE_CR_VALUE:   push_text("Key: val\015x\015\n");
        SC_NO_LENGTH_DIGIT: push_header("Content-Length", " abc");
        SC_LENGTH_OVERFLOW: push_header("Content-Length",
                                        $urandom_range(1) ? " 4294967296" : " 99999999999");
        default: begin
          body_len = 0;
          if (scenario == SC_COMPLETE) begin
            if ($urandom_range(9) != 0) body_len = $urandom_range(300, 700);
            push_header("Content-Length", $sformatf(" %0d", body_len));
          end
          push_text("\015\n");
          repeat (body_len) add_byte(8'($urandom_range(255)));
        end
      endcase
    end
    repeat (40) add_byte(8'($urandom_range(255)));
    while (stream_q.size() < STREAM_BYTES) add_byte(8'($urandom_range(255)));
  endtask

  function automatic void check_field(input string field, input longint unsigned want_v,
                                      input longint unsigned got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, got %0d", field, want_v, got_v);
      errors++;
    end
  endfunction

  // sender: offers the next byte unless idling or paused for a full drain
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_if.valid || in_sent) begin
        if (stream_q.size() != 0 && $urandom_range(99) >= send_idle_pct &&
            !(bytes_in == n_total / 2 && event_q.size() != 0)) begin
          in_if.valid     <= 1'b1;
          in_if.data_byte <= stream_q.pop_front();
        end else begin
          in_if.valid     <= 1'b0;
          in_if.data_byte <= 8'($urandom_range(255));
        end
      end
    end
  end

  // receiver: random backpressure plus one long hold-off
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      out_if.ready <= 1'b0;
    end else if (events_out == STALL_AT && !stall_done) begin
      stall_left   <= STALL_CYCLES;
      stall_done   <= 1'b1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= $urandom_range(99) >= recv_idle_pct;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_sent   = in_if.valid && in_if.ready;
      out_taken = out_if.valid && out_if.ready;
      if (in_sent) begin
        event_q.insert(event_q.size(), parse_byte(in_if.data_byte));
        bytes_in++;
      end
      if (out_taken) begin
        if (event_q.size() == 0) begin
          $error("event with no byte pending: kind %0d", out_if.kind);
          errors++;
        end else begin
          want = event_q.pop_front();
          check_field("kind", want.kind, out_if.kind);
          check_field("byte_value", want.byte_value, out_if.byte_value);
          check_field("resp_code", want.resp_code, out_if.resp_code);
          check_field("body_length", want.body_length, out_if.body_length);
          check_field("last", want.last, out_if.last);
        end
        kind_count[out_if.kind]++;
        events_out++;
      end
      if (bytes_in < n_total / 3) begin
        send_idle_pct = 25;
        recv_idle_pct = 49;
      end else if (bytes_in < 2 * n_total / 3) begin
        send_idle_pct = 49;
        recv_idle_pct = 25;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      idle_cycles = (in_sent || out_taken) ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("stalled: %0d bytes in, %0d events out", bytes_in, events_out);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    in_if.valid     = 1'b0;
    in_if.data_byte = 8'd0;
    out_if.ready    = 1'b0;
    reset_parser();
    build_response();
    n_total = stream_q.size();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    while (bytes_in < n_total) @(posedge clk_i);
    while (event_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    $display("stream %s: %0d bytes, %0d events (%0d status, %0d name, %0d value, %0d body)",
             scenario.name(), bytes_in, events_out, kind_count[hrp_pkg::K_STATUS],
             kind_count[hrp_pkg::K_NAME], kind_count[hrp_pkg::K_VALUE],
             kind_count[hrp_pkg::K_BODY]);
    $display("header lines %0d, headers done %0d, errors %0d, ignored %0d",
             kind_count[hrp_pkg::K_LINE_END], kind_count[hrp_pkg::K_HDR_DONE],
             kind_count[hrp_pkg::K_ERROR], kind_count[hrp_pkg::K_IGNORED]);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
